/* rtl/sem_pkg.sv */
// shared constants and types for the sobel edge magnitude block
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int CFG_W      = 11;
  localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);
  localparam int CMP_W      = ((CFG_W > ROW_W) ? CFG_W : ROW_W) + 2;
  localparam int PIX_W      = 24;

  // register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
endpackage
`default_nettype wire

/* rtl/sem_pix_if.sv */
// input pixel channel
`timescale 1ns / 1ps
`default_nettype none
interface sem_pix_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, output mode, output red, output green, output blue,
                  input ready);
  modport sink (input valid, input mode, input red, input green, input blue,
                output ready);
endinterface
`default_nettype wire

/* rtl/sem_res_if.sv */
// result channel
`timescale 1ns / 1ps
`default_nettype none
interface sem_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_red;
  logic [7:0] edge_green;
  logic [7:0] edge_blue;
  logic       last_of_run;
  logic       end_of_frame;
  modport source (output valid, output edge_red, output edge_green, output edge_blue,
                  output last_of_run, output end_of_frame, input ready);
  modport sink (input valid, input edge_red, input edge_green, input edge_blue,
                input last_of_run, input end_of_frame, output ready);
endinterface
`default_nettype wire

/* rtl/sem_ram.sv */
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

/* rtl/sobel_edge_magnitude.sv */
// top level: streaming 3x3 sobel edge magnitude on rgb pixels
`timescale 1ns / 1ps
`default_nettype none
// Takes one rgb pixel beat at a time in raster order and returns, per channel,
// min(255, round(sqrt(gx^2 + gy^2))) of the 3x3 sobel operator with zero
// outside the frame. A result lags its pixel by one row and one column; after
// the frame send one row of flush beats (mode = 1). An end-of-row beat past
// the first row gives two results (one if the row is one pixel wide), the
// last flagged end_of_frame on the flush row; last_of_run marks the final
// result of each beat. The two previous rows sit in two rams (one read, then
// one write per beat). Each beat is read from the rams and then updates the
// window; each result then goes through gradient, squares, 8-step root search
// and output load, and waits there while the result register is full. A new
// beat is taken only once the last beat's results are loaded. The result
// register lets a new beat be taken while the last result waits.
module sobel_edge_magnitude
  import sem_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  sem_pix_if.sink               pix_i,
  sem_res_if.source             res_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_GRAD = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_ROOT = 3'd4;
  localparam logic [2:0] S_PUT  = 3'd5;

  logic [2:0] state_q, state_d;

  // configuration
  logic [CFG_W-1:0] width_q, height_q;
  logic [CMP_W-1:0] w_eff, h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(1024);
      height_q <= CFG_W'(1024);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the maximum as the maximum
  always_comb begin
    w_eff = CMP_W'(width_q);
    if (width_q == '0) w_eff = CMP_W'(1);
    else if (CMP_W'(width_q) > CMP_W'(MAX_WIDTH)) w_eff = CMP_W'(MAX_WIDTH);
    h_eff = CMP_W'(height_q);
    if (height_q == '0) h_eff = CMP_W'(1);
    else if (CMP_W'(height_q) > CMP_W'(MAX_HEIGHT)) h_eff = CMP_W'(MAX_HEIGHT);
  end

  // position counters and per-beat flags
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             accept;
  logic             flush_row, end_row;
  pix_t             px_in;

  assign accept    = pix_i.valid && pix_i.ready;
  assign flush_row = CMP_W'(row_q) >= h_eff;
  assign end_row   = (CMP_W'(col_q) + CMP_W'(1)) >= w_eff;
  assign px_in     = (!pix_i.mode && !flush_row) ? {pix_i.blue, pix_i.green, pix_i.red} : '0;

  pix_t px_q;
  logic [COL_W-1:0] wcol_q;
  logic c0_q, r1_q, r2_q, endr_q, flush_q;
  logic want_a_q, want_b_q, sel_b_q;

  // line buffers
  pix_t one_rd, two_rd;
  logic ram_we;

  assign ram_we = (state_q == S_UPD);

  // write back at the column the beat was read from
  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_one (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wcol_q),
    .wdata_i (px_q),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (one_rd)
  );

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_two (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wcol_q),
    .wdata_i (one_rd),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (two_rd)
  );

  // 3x3 window, oldest column in column 0
  pix_t win_q [9];
  pix_t nb [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) win_q[k] <= '0;
    end else if (state_q == S_UPD) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k*3]   <= c0_q ? '0 : win_q[k*3+1];
        win_q[k*3+1] <= c0_q ? '0 : win_q[k*3+2];
      end
      win_q[2] <= r2_q ? two_rd : '0;
      win_q[5] <= r1_q ? one_rd : '0;
      win_q[8] <= px_q;
    end
  end

  // the end-of-row result sees the window shifted once more with a zero column
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nb[k*3]   = sel_b_q ? win_q[k*3+1] : win_q[k*3];
      nb[k*3+1] = sel_b_q ? win_q[k*3+2] : win_q[k*3+1];
      nb[k*3+2] = sel_b_q ? '0 : win_q[k*3+2];
    end
  end

  // gradient, squares and root search per channel
  logic [9:0]  ax_q [3], ay_q [3];
  logic [22:0] q_q  [3];
  logic [7:0]  n_q  [3];
  logic [2:0]  bit_q;
  logic [9:0]  ax_d [3], ay_d [3];
  logic [7:0]  n_d  [3];

  always_comb begin
    logic signed [11:0] v [9];
    logic signed [11:0] gx, gy;
    logic [7:0]  t;
    logic [8:0]  dd;
    logic [17:0] dsq;
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) v[k] = $signed({4'b0, nb[k][8*ch +: 8]});
      gx = v[2] - v[0] + ((v[5] - v[3]) <<< 1) + v[8] - v[6];
      gy = v[6] - v[0] + ((v[7] - v[1]) <<< 1) + v[8] - v[2];
      ax_d[ch] = gx[11] ? 10'(-gx) : gx[9:0];
      ay_d[ch] = gy[11] ? 10'(-gy) : gy[9:0];
      // binary search for largest n with (2n-1)^2 <= 4*gsq
      t   = n_q[ch] | (8'd1 << bit_q);
      dd  = {t, 1'b0} - 9'd1;
      dsq = dd * dd;
      n_d[ch] = (23'(dsq) <= q_q[ch]) ? t : n_q[ch];
    end
  end

  // result register
  logic [7:0] out_q [3];
  logic       out_valid_q, out_last_q, out_eof_q;
  logic       out_free;

  assign out_free = !out_valid_q || res_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_UPD;
      S_UPD:  state_d = (r1_q && (!c0_q || endr_q)) ? S_GRAD : S_IDLE;
      S_GRAD: state_d = S_SQ;
      S_SQ:   state_d = S_ROOT;
      S_ROOT: if (bit_q == 3'd0) state_d = S_PUT;
      S_PUT:  if (out_free) state_d = (!sel_b_q && want_b_q) ? S_GRAD : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      want_a_q    <= 1'b0;
      want_b_q    <= 1'b0;
      sel_b_q     <= 1'b0;
      bit_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_UPD) begin
        want_a_q <= r1_q && !c0_q;
        want_b_q <= r1_q && endr_q;
        sel_b_q  <= !(r1_q && !c0_q);
      end
      if (state_q == S_SQ) bit_q <= 3'd7;
      else if (state_q == S_ROOT) bit_q <= bit_q - 3'd1;
      if (state_q == S_PUT && out_free) begin
        out_valid_q <= 1'b1;
        sel_b_q     <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        if (end_row) begin
          col_q <= '0;
          row_q <= flush_row ? '0 : row_q + ROW_W'(1);
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q    <= px_in;
      wcol_q  <= col_q;
      c0_q    <= (col_q == '0);
      r1_q    <= (row_q != '0);
      r2_q    <= (row_q >= ROW_W'(2));
      endr_q  <= end_row;
      flush_q <= flush_row;
    end
    for (int ch = 0; ch < 3; ch++) begin
      if (state_q == S_GRAD) begin
        ax_q[ch] <= ax_d[ch];
        ay_q[ch] <= ay_d[ch];
      end
      if (state_q == S_SQ) begin
        q_q[ch] <= {(21'(ax_q[ch] * ax_q[ch]) + 21'(ay_q[ch] * ay_q[ch])), 2'b00};
        n_q[ch] <= '0;
      end
      if (state_q == S_ROOT) n_q[ch] <= n_d[ch];
    end
    if (state_q == S_PUT && out_free) begin
      for (int ch = 0; ch < 3; ch++) out_q[ch] <= n_q[ch];
      out_last_q <= sel_b_q || !want_b_q;
      out_eof_q  <= sel_b_q && flush_q;
    end
  end

  assign pix_i.ready        = (state_q == S_IDLE);
  assign res_o.valid        = out_valid_q;
  assign res_o.edge_red     = out_q[0];
  assign res_o.edge_green   = out_q[1];
  assign res_o.edge_blue    = out_q[2];
  assign res_o.last_of_run  = out_last_q;
  assign res_o.end_of_frame = out_eof_q;

  // checks
  a_accept_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_UPD)
    else $error("beat accepted but no window update followed");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (!res_o.end_of_frame || res_o.last_of_run))
    else $error("end of frame result not last of run");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(row_q) <= CMP_W'(MAX_HEIGHT))
    else $error("row counter out of range");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GRAD && !sel_b_q) |-> want_a_q)
    else $error("first result computed without being due");
endmodule
`default_nettype wire
